FILE: rtl/itf_pkg.sv
// Shared types, constants and helpers for the integer text formatter.
// No dependencies; used by itf_digit_unit and integer_text_formatter_top.
package itf_pkg;

  localparam int unsigned MaxFieldWidth = 48;
  localparam int unsigned DigitMax      = 32;
  localparam int unsigned DigIdxW       = $clog2(DigitMax);

  localparam logic [2:0] FuncSdec = 3'd0;
  localparam logic [2:0] FuncUdec = 3'd1;
  localparam logic [2:0] FuncHex  = 3'd2;
  localparam logic [2:0] FuncOct  = 3'd3;
  localparam logic [2:0] FuncBin  = 3'd4;
  localparam logic [2:0] FuncPtr  = 3'd5;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSpace  = 8'h20;

  // ceil(2^35 / 10): floor(x * RecipTen / 2^35) == x / 10 for all 32-bit x
  localparam logic [31:0] RecipTen = 32'hCCCCCCCD;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_e;

  typedef struct packed {
    logic   start;
    radix_e radix;
  } du_req_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'b0000, d};
    end else begin
      c = CharUpperA + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: rtl/itf_digit_unit.sv
// Shared digit extraction unit: one quotient and remainder per request.
// Decimal uses a registered reciprocal multiply; powers of two use shifts.
// Depends on itf_pkg.
module itf_digit_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  itf_pkg::du_req_t req_i,
  input  logic [31:0]     mag_i,
  output logic            done_o,
  output logic [31:0]     quo_o,
  output logic [3:0]      rem_o
);

  logic                 valid_q;
  logic [31:0]          mag_q;
  itf_pkg::radix_e      radix_q;
  logic [28:0]          prod_q;
  logic [63:0]          prod_full;
  logic [31:0]          quo;
  logic [31:0]          rem_w;

  assign prod_full = {32'b0, mag_i} * {32'b0, itf_pkg::RecipTen};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q   <= mag_i;
      radix_q <= req_i.radix;
      prod_q  <= prod_full[63:35];
    end
  end

  always_comb begin
    quo   = '0;
    rem_w = '0;
    case (radix_q)
      itf_pkg::RADIX_DEC: begin
        quo   = {3'b000, prod_q};
        rem_w = mag_q - (quo << 3) - (quo << 1);
      end
      itf_pkg::RADIX_HEX: begin
        quo   = mag_q >> 4;
        rem_w = {28'b0, mag_q[3:0]};
      end
      itf_pkg::RADIX_OCT: begin
        quo   = mag_q >> 3;
        rem_w = {29'b0, mag_q[2:0]};
      end
      itf_pkg::RADIX_BIN: begin
        quo   = mag_q >> 1;
        rem_w = {31'b0, mag_q[0]};
      end
      default: begin
        quo   = '0;
        rem_w = '0;
      end
    endcase
  end

  assign done_o = valid_q;
  assign quo_o  = quo;
  assign rem_o  = rem_w[3:0];

  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_i.start))
    else $error("digit unit done without a request");

  a_dec_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (radix_q == itf_pkg::RADIX_DEC) |-> (rem_o < 4'd10) && (quo_o <= mag_q))
    else $error("decimal remainder out of range");

endmodule

FILE: rtl/integer_text_formatter_top.sv
// Integer text formatter top: sequencer, digit store and character output.
// Each digit passes through S_START and S_WAIT; S_LAYOUT then sets up the field before emit.
// A new item is taken only when idle, after its last char; one char per cycle unless out_stall_i holds.
// Reset (rst_ni low, asynchronous): idle, output empty. Uses itf_pkg, itf_digit_unit.
module integer_text_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] value_i,
  input  logic        flag_left_i,
  input  logic        flag_plus_i,
  input  logic        flag_space_i,
  input  logic        flag_zero_i,
  input  logic        flag_alt_i,
  input  logic [5:0]  width_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_LAYOUT,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SEG_PAD,
    SEG_PFX,
    SEG_DIG
  } seg_e;

  state_e              state_q;
  itf_pkg::radix_e     radix_q;
  logic [31:0]         mag_q;
  logic [5:0]          nd_q;
  logic [5:0]          width_q;
  logic                has_sign_q;
  logic [7:0]          sign_q;
  logic                alt_q;
  logic                zero_q;
  logic                left_q;
  logic [6:0]          b1_q;
  logic [6:0]          b2_q;
  seg_e                seg1_q;
  seg_e                seg2_q;
  seg_e                seg3_q;
  logic [6:0]          pos_q;
  logic [6:0]          last_pos_q;
  logic                out_valid_q;
  logic [7:0]          out_char_q;
  logic                out_last_q;
  logic [3:0]          digits_q [itf_pkg::DigitMax];

  itf_pkg::du_req_t    du_req;
  logic                du_done;
  logic [31:0]         du_quo;
  logic [3:0]          du_rem;

  logic                accept;
  logic                load;
  logic [5:0]          width_sat;
  logic                neg;
  itf_pkg::radix_e     radix_in;
  logic [1:0]          plen;
  logic [6:0]          cnt;
  logic [6:0]          pad;
  logic [6:0]          off;
  seg_e                seg;
  logic [6:0]          dig_pos;
  logic [7:0]          char_d;
  logic                last_d;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign load      = !out_valid_q || !out_stall_i;
  assign width_sat = (width_i > 6'(itf_pkg::MaxFieldWidth)) ?
                     6'(itf_pkg::MaxFieldWidth) : width_i;
  assign neg       = (func_i == itf_pkg::FuncSdec) && value_i[31];

  always_comb begin
    case (func_i)
      itf_pkg::FuncHex, itf_pkg::FuncPtr: radix_in = itf_pkg::RADIX_HEX;
      itf_pkg::FuncOct:                   radix_in = itf_pkg::RADIX_OCT;
      itf_pkg::FuncBin:                   radix_in = itf_pkg::RADIX_BIN;
      default:                            radix_in = itf_pkg::RADIX_DEC;
    endcase
  end

  assign du_req.start = (state_q == S_START);
  assign du_req.radix = radix_q;

  itf_digit_unit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (du_req),
    .mag_i  (mag_q),
    .done_o (du_done),
    .quo_o  (du_quo),
    .rem_o  (du_rem)
  );

  // layout of the field
  always_comb begin
    plen = has_sign_q ? 2'd1 : (alt_q ? 2'd2 : 2'd0);
    cnt  = {1'b0, nd_q} + ((zero_q && alt_q) ? 7'd0 : {5'b0, plen});
    pad  = ({1'b0, width_q} > cnt) ? ({1'b0, width_q} - cnt) : 7'd0;
  end

  // character at the current position
  always_comb begin
    if (pos_q < b1_q) begin
      seg = seg1_q;
      off = pos_q;
    end else if (pos_q < b2_q) begin
      seg = seg2_q;
      off = pos_q - b1_q;
    end else begin
      seg = seg3_q;
      off = pos_q - b2_q;
    end
    dig_pos = {1'b0, nd_q} - 7'd1 - off;
    case (seg)
      SEG_PAD: char_d = zero_q ? itf_pkg::CharZero : itf_pkg::CharSpace;
      SEG_PFX: char_d = has_sign_q ? sign_q :
                        ((off == 7'd0) ? itf_pkg::CharZero : itf_pkg::CharX);
      SEG_DIG: char_d = itf_pkg::digit_char(digits_q[dig_pos[itf_pkg::DigIdxW-1:0]]);
      default: char_d = itf_pkg::CharSpace;
    endcase
    last_d = (pos_q == last_pos_q);
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_WAIT) && du_done) begin
      digits_q[nd_q[itf_pkg::DigIdxW-1:0]] <= du_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= itf_pkg::RADIX_DEC;
      mag_q       <= '0;
      nd_q        <= '0;
      width_q     <= '0;
      has_sign_q  <= 1'b0;
      sign_q      <= '0;
      alt_q       <= 1'b0;
      zero_q      <= 1'b0;
      left_q      <= 1'b0;
      b1_q        <= '0;
      b2_q        <= '0;
      seg1_q      <= SEG_PAD;
      seg2_q      <= SEG_PAD;
      seg3_q      <= SEG_PAD;
      pos_q       <= '0;
      last_pos_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (load && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            radix_q    <= radix_in;
            mag_q      <= neg ? (32'd0 - value_i) : value_i;
            nd_q       <= '0;
            width_q    <= width_sat;
            has_sign_q <= (func_i == itf_pkg::FuncSdec) &&
                          (value_i[31] || flag_plus_i || flag_space_i);
            sign_q     <= neg ? itf_pkg::CharMinus :
                          (flag_plus_i ? itf_pkg::CharPlus : itf_pkg::CharSpace);
            alt_q      <= (func_i == itf_pkg::FuncHex) && flag_alt_i;
            zero_q     <= flag_zero_i;
            left_q     <= flag_left_i;
            state_q    <= S_START;
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (du_done) begin
            nd_q  <= nd_q + 6'd1;
            mag_q <= du_quo;
            if ((du_quo == 32'd0) || (nd_q == 6'(itf_pkg::DigitMax - 1))) begin
              state_q <= S_LAYOUT;
            end else begin
              state_q <= S_START;
            end
          end
        end
        S_LAYOUT: begin
          pos_q      <= '0;
          last_pos_q <= {5'b0, plen} + {1'b0, nd_q} + pad - 7'd1;
          if (zero_q) begin
            b1_q   <= {5'b0, plen};
            b2_q   <= {5'b0, plen} + pad;
            seg1_q <= SEG_PFX;
            seg2_q <= SEG_PAD;
            seg3_q <= SEG_DIG;
          end else if (!left_q) begin
            b1_q   <= pad;
            b2_q   <= pad + {5'b0, plen};
            seg1_q <= SEG_PAD;
            seg2_q <= SEG_PFX;
            seg3_q <= SEG_DIG;
          end else begin
            b1_q   <= {5'b0, plen};
            b2_q   <= {5'b0, plen} + {1'b0, nd_q};
            seg1_q <= SEG_PFX;
            seg2_q <= SEG_DIG;
            seg3_q <= SEG_PAD;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_char_q  <= char_d;
            out_last_q  <= last_d;
            pos_q       <= pos_q + 7'd1;
            if (last_d) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted but sequencer not busy");

  a_digit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= 6'(itf_pkg::DigitMax))
    else $error("digit count overflow");

  a_pos_in_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (pos_q <= last_pos_q))
    else $error("emit position past end of field");

  a_last_ends_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && load && last_d |=> (state_q == S_IDLE) && last_o)
    else $error("final word did not end the item");

endmodule

FILE: test/integer_text_formatter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_text_formatter_top: directed table, then random words.
// Character words are predicted in-bench and checked in order. Uses itf_pkg.
module integer_text_formatter_top_tb;

  localparam logic [2:0] FuncSpare6 = 3'd6;
  localparam logic [2:0] FuncSpare7 = 3'd7;

  localparam logic [4:0] FlNone  = 5'b00000;
  localparam logic [4:0] FlLeft  = 5'b10000;
  localparam logic [4:0] FlPlus  = 5'b01000;
  localparam logic [4:0] FlSpace = 5'b00100;
  localparam logic [4:0] FlZero  = 5'b00010;
  localparam logic [4:0] FlAlt   = 5'b00001;

  localparam int DirRows    = 24;
  localparam int RandWords  = 88;
  localparam int DrainCycles = 100;
  localparam int CycleLimit = 800000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        flag_left;
    logic        flag_plus;
    logic        flag_space;
    logic        flag_zero;
    logic        flag_alt;
    logic [5:0]  width;
  } word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  func_i;
  logic [31:0] value_i;
  logic        flag_left_i;
  logic        flag_plus_i;
  logic        flag_space_i;
  logic        flag_zero_i;
  logic        flag_alt_i;
  logic [5:0]  width_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_char_o;
  logic        last_o;

  char_t text_q [$];
  int    errors = 0;
  int    cycle_count = 0;
  bit    idle_in = 1'b1;
  bit    idle_out = 1'b1;
  word_t dir_words [DirRows];
  string dir_text [DirRows];

  integer_text_formatter_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .flag_left_i  (flag_left_i),
    .flag_plus_i  (flag_plus_i),
    .flag_space_i (flag_space_i),
    .flag_zero_i  (flag_zero_i),
    .flag_alt_i   (flag_alt_i),
    .width_i      (width_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_o       (last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic word_t make_word(input logic [2:0] kind, input logic [31:0] value,
                                      input logic [4:0] flags, input logic [5:0] width);
    word_t w;
    w.kind = kind;
    w.value = value;
    {w.flag_left, w.flag_plus, w.flag_space, w.flag_zero, w.flag_alt} = flags;
    w.width = width;
    return w;
  endfunction

  function automatic void queue_text(input word_t w);
    logic [31:0] mag;
    logic [31:0] base;
    logic [3:0]  d;
    logic [7:0]  dig [32];
    logic [7:0]  sgn;
    logic [7:0]  txt [$];
    int          nd;
    int          fw;
    int          plen;
    int          counted;
    int          pad;
    mag = w.value;
    sgn = 8'h00;
    plen = 0;
    nd = 0;
    fw = (w.width > itf_pkg::MaxFieldWidth) ? itf_pkg::MaxFieldWidth : w.width;
    case (w.kind)
      itf_pkg::FuncHex, itf_pkg::FuncPtr: base = 16;
      itf_pkg::FuncOct:                   base = 8;
      itf_pkg::FuncBin:                   base = 2;
      default:                            base = 10;
    endcase
    if (w.kind == itf_pkg::FuncSdec) begin
      if (w.value[31]) begin
        sgn = itf_pkg::CharMinus;
        mag = -w.value;
      end else if (w.flag_plus) begin
        sgn = itf_pkg::CharPlus;
      end else if (w.flag_space) begin
        sgn = itf_pkg::CharSpace;
      end
    end
    if (w.kind == itf_pkg::FuncHex && w.flag_alt) plen = 2;
    do begin
      d = 4'(mag % base);
      dig[nd] = (d < 10) ? itf_pkg::CharZero + d : itf_pkg::CharUpperA + d - 8'd10;
      mag = mag / base;
      nd++;
    end while (mag != 0 && nd < 32);
    // hex prefix is outside the width when zero padding
    counted = nd + ((sgn != 8'h00) ? 1 : 0) + (w.flag_zero ? 0 : plen);
    pad = (fw > counted) ? fw - counted : 0;
    if (!w.flag_zero && !w.flag_left) repeat (pad) txt.push_back(itf_pkg::CharSpace);
    if (sgn != 8'h00) txt.push_back(sgn);
    if (plen != 0) begin
      txt.push_back(itf_pkg::CharZero);
      txt.push_back(itf_pkg::CharX);
    end
    if (w.flag_zero) repeat (pad) txt.push_back(itf_pkg::CharZero);
    for (int i = nd - 1; i >= 0; i--) txt.push_back(dig[i]);
    if (w.flag_left && !w.flag_zero) repeat (pad) txt.push_back(itf_pkg::CharSpace);
    for (int i = 0; i < txt.size(); i++) text_q.push_back({txt[i], i == txt.size() - 1});
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.kind = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0: w.value = $urandom;
      1: w.value = $urandom_range(0, 99);
      2: w.value = -$urandom_range(1, 1000);
      3: w.value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
      default: w.value = $urandom >> $urandom_range(0, 31);
    endcase
    {w.flag_left, w.flag_plus, w.flag_space, w.flag_zero, w.flag_alt} =
        5'($urandom_range(0, 31));
    w.width = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 20)) :
                                            6'($urandom_range(21, 63));
    return w;
  endfunction

  task automatic send_word(input word_t w, input string txt);
    int gap;
    gap = idle_in ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i <= w.kind;
    value_i <= w.value;
    flag_left_i <= w.flag_left;
    flag_plus_i <= w.flag_plus;
    flag_space_i <= w.flag_space;
    flag_zero_i <= w.flag_zero;
    flag_alt_i <= w.flag_alt;
    width_i <= w.width;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (txt.len() == 0) begin
      queue_text(w);
    end else begin
      for (int i = 0; i < txt.len(); i++) text_q.push_back({txt[i], i == txt.len() - 1});
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (text_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // receiver: before each word, stall for a randomly drawn gap when idle_out is set
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_out ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      if (text_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: char %h last %b", out_char_o, last_o);
      end else begin
        want = text_q.pop_front();
        if (out_char_o !== want.ch || last_o !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.last, out_char_o, last_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    func_i <= itf_pkg::FuncSdec;
    value_i <= '0;
    flag_left_i <= 1'b0;
    flag_plus_i <= 1'b0;
    flag_space_i <= 1'b0;
    flag_zero_i <= 1'b0;
    flag_alt_i <= 1'b0;
    width_i <= '0;
    out_stall_i <= 1'b0;

    dir_words[0]  = make_word(itf_pkg::FuncSdec, 32'd0, FlNone, 6'd0);
    dir_text[0]   = "0";
    dir_words[1]  = make_word(itf_pkg::FuncSdec, 32'h8000_0000, FlNone, 6'd0);
    dir_text[1]   = "-2147483648";
    dir_words[2]  = make_word(itf_pkg::FuncSdec, 32'h7FFF_FFFF, FlPlus, 6'd0);
    dir_text[2]   = "+2147483647";
    dir_words[3]  = make_word(itf_pkg::FuncSdec, 32'd5, FlSpace, 6'd0);
    dir_text[3]   = " 5";
    dir_words[4]  = make_word(itf_pkg::FuncSdec, -32'd42, FlZero, 6'd8);
    dir_text[4]   = "-0000042";
    dir_words[5]  = make_word(itf_pkg::FuncSdec, 32'd42, FlLeft, 6'd6);
    dir_text[5]   = "42    ";
    dir_words[6]  = make_word(itf_pkg::FuncSdec, -32'd42, FlLeft | FlZero, 6'd6);
    dir_text[6]   = "-00042";
    dir_words[7]  = make_word(itf_pkg::FuncUdec, 32'hFFFF_FFFF, FlPlus, 6'd0);
    dir_text[7]   = "4294967295";
    dir_words[8]  = make_word(itf_pkg::FuncHex, 32'd0, FlAlt, 6'd0);
    dir_text[8]   = "0x0";
    dir_words[9]  = make_word(itf_pkg::FuncHex, 32'hDEAD_BEEF, FlAlt | FlZero, 6'd10);
    dir_text[9]   = "0x00DEADBEEF";
    dir_words[10] = make_word(itf_pkg::FuncHex, 32'h0ABC, FlAlt, 6'd8);
    dir_text[10]  = "   0xABC";
    dir_words[11] = make_word(itf_pkg::FuncHex, 32'h0ABC, FlAlt | FlLeft, 6'd8);
    dir_text[11]  = "0xABC   ";
    dir_words[12] = make_word(itf_pkg::FuncPtr, 32'hFFFF_FFFF, FlAlt, 6'd0);
    dir_text[12]  = "FFFFFFFF";
    dir_words[13] = make_word(itf_pkg::FuncOct, 32'hFFFF_FFFF, FlNone, 6'd0);
    dir_text[13]  = "37777777777";
    dir_words[14] = make_word(itf_pkg::FuncBin, 32'hFFFF_FFFF, FlNone, 6'd0);
    dir_text[14]  = "";
    dir_words[15] = make_word(itf_pkg::FuncBin, 32'd5, FlZero, 6'd8);
    dir_text[15]  = "00000101";
    dir_words[16] = make_word(itf_pkg::FuncOct, 32'd8, FlNone, 6'd4);
    dir_text[16]  = "  10";
    dir_words[17] = make_word(FuncSpare6, 32'd123, FlPlus, 6'd0);
    dir_text[17]  = "123";
    dir_words[18] = make_word(FuncSpare7, 32'hFFFF_FFFF, FlSpace, 6'd0);
    dir_text[18]  = "4294967295";
    dir_words[19] = make_word(itf_pkg::FuncUdec, 32'd7, FlNone, 6'd63);
    dir_text[19]  = "";
    dir_words[20] = make_word(itf_pkg::FuncSdec, 32'hFFFF_FFFF, FlZero, 6'd63);
    dir_text[20]  = "";
    dir_words[21] = make_word(itf_pkg::FuncHex, 32'd1, FlAlt | FlZero | FlLeft, 6'd63);
    dir_text[21]  = "";
    dir_words[22] = make_word(itf_pkg::FuncBin, 32'd0, FlLeft, 6'd3);
    dir_text[22]  = "0  ";
    dir_words[23] = make_word(itf_pkg::FuncUdec, 32'd0, FlLeft | FlPlus | FlSpace, 6'd48);
    dir_text[23]  = "";

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) send_word(dir_words[i], dir_text[i]);
    wait_drain();

    for (int i = 0; i < RandWords; i++) begin
      if (i % 16 == 0) begin
        idle_in = $urandom_range(0, 3) != 0;
        idle_out = $urandom_range(0, 3) != 0;
      end
      if (i == RandWords / 2) wait_drain();
      send_word(random_word(), "");
    end
    wait_drain();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
